>>> rtl/dss_pkg.sv
// Package: shared types, codes and the coil pattern table for the dual stepper sequencer.
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

  // Default step count for one revolution
  localparam int unsigned STEPS_PER_REV_DEF = 200;

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // Load mode codes
  localparam logic [3:0] LOAD_FIRST_FWD  = 4'd1;
  localparam logic [3:0] LOAD_FIRST_REV  = 4'd2;
  localparam logic [3:0] LOAD_SECOND_FWD = 4'd3;
  localparam logic [3:0] LOAD_SECOND_REV = 4'd4;
  localparam logic [3:0] LOAD_BRAKE_BOTH = 4'd9;

  // Index values after reset or stop
  localparam logic [2:0] FWD_IDX_INIT = 3'd7;
  localparam logic [2:0] REV_IDX_INIT = 3'd4;
  localparam logic [2:0] IDX_LAST     = 3'd3;
  localparam logic [3:0] COILS_ALL_ON = 4'hF;

  // Motor mode
  typedef enum logic [1:0] {
    MODE_COAST = 2'd0,
    MODE_FWD   = 2'd1,
    MODE_REV   = 2'd2,
    MODE_BRAKE = 2'd3
  } mode_e;

  // Input transaction
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] mode_code;
    logic [3:0] target_tens;
    logic [3:0] target_units;
  } dss_in_t;

  // Result transaction
  typedef struct packed {
    logic [3:0] first_coils;
    logic       first_driven;
    logic [3:0] second_coils;
    logic       second_driven;
    logic [1:0] first_mode;
    logic [1:0] second_mode;
    logic       red_indicator;
    logic       stopped_now;
    logic [7:0] first_revs;
    logic [7:0] second_revs;
  } dss_out_t;

  // Per-motor control for one transaction
  typedef struct packed {
    logic       en;
    logic       tick;
    logic       load;
    mode_e      load_mode;
    logic [7:0] load_target;
    logic       halt;
  } motor_ctrl_t;

  // Per-motor state after the transaction, as reported
  typedef struct packed {
    logic [3:0] coils;
    logic       driven;
    mode_e      mode;
    logic [7:0] revs;
  } motor_view_t;

  // Per-motor status toward the top level
  typedef struct packed {
    logic rev_done;
    logic target_hit;
  } motor_stat_t;

  // Full-step coil pattern
  function automatic logic [3:0] coil_pattern(input logic [1:0] idx);
    logic [3:0] pat;
    case (idx)
      2'd0:    pat = 4'b0101;
      2'd1:    pat = 4'b0110;
      2'd2:    pat = 4'b1010;
      default: pat = 4'b1001;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dss_motor.sv
// Motor channel: mode, target, phase indices, step and revolution counters, coil latch.
`timescale 1ns / 1ps
`default_nettype none

module dss_motor
  import dss_pkg::*;
#(
  parameter int unsigned StepsPerRev = STEPS_PER_REV_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  motor_ctrl_t  ctrl_i,
  output motor_view_t  view_o,
  output motor_stat_t  stat_o
);

  localparam logic [7:0] StepsLast = 8'(StepsPerRev);

  mode_e      mode_q, mode_d;
  logic [7:0] target_q, target_d;
  logic [2:0] fwd_idx_q, fwd_idx_d;
  logic [2:0] rev_idx_q, rev_idx_d;
  logic [7:0] steps_q, steps_d;
  logic [7:0] revs_q, revs_d;
  logic [3:0] coils_q, coils_d;
  logic       driven;

  // Step advance for a tick
  logic [2:0] fwd_adv, rev_adv, fwd_inc;
  logic       step_inc, moving;
  logic [7:0] steps_adv, revs_adv;
  logic [3:0] coils_adv;
  logic       rev_done;

  always_comb begin
    fwd_inc   = (fwd_idx_q == FWD_IDX_INIT) ? 3'd0 : fwd_idx_q + 3'd1;
    fwd_adv   = fwd_idx_q;
    rev_adv   = rev_idx_q;
    step_inc  = 1'b0;
    moving    = 1'b0;
    coils_adv = coils_q;
    case (mode_q)
      MODE_FWD: begin
        moving = 1'b1;
        if (fwd_inc > IDX_LAST) begin
          fwd_adv  = 3'd0;
          step_inc = 1'b1;
        end else begin
          fwd_adv = fwd_inc;
        end
        coils_adv = coil_pattern(fwd_adv[1:0]);
      end
      MODE_REV: begin
        moving = 1'b1;
        if (rev_idx_q == 3'd0) begin
          rev_adv  = IDX_LAST;
          step_inc = 1'b1;
        end else begin
          rev_adv = rev_idx_q - 3'd1;
        end
        coils_adv = coil_pattern(rev_adv[1:0]);
      end
      default: ;
    endcase
    steps_adv = steps_q + {7'd0, step_inc};
    rev_done  = ctrl_i.tick && (steps_adv == StepsLast);
    revs_adv  = revs_q + 8'd1;
  end

  assign stat_o.rev_done   = rev_done;
  assign stat_o.target_hit = rev_done && (revs_adv == target_q);

  // Next state: stop wins over load and tick
  always_comb begin
    mode_d    = mode_q;
    target_d  = target_q;
    fwd_idx_d = fwd_idx_q;
    rev_idx_d = rev_idx_q;
    steps_d   = steps_q;
    revs_d    = revs_q;
    coils_d   = coils_q;
    driven    = 1'b0;
    if (ctrl_i.halt) begin
      mode_d    = MODE_BRAKE;
      target_d  = 8'd0;
      fwd_idx_d = FWD_IDX_INIT;
      rev_idx_d = REV_IDX_INIT;
      steps_d   = 8'd0;
      revs_d    = 8'd0;
      coils_d   = COILS_ALL_ON;
      driven    = 1'b1;
    end else if (ctrl_i.load) begin
      mode_d   = ctrl_i.load_mode;
      target_d = ctrl_i.load_target;
    end else if (ctrl_i.tick) begin
      fwd_idx_d = fwd_adv;
      rev_idx_d = rev_adv;
      coils_d   = coils_adv;
      driven    = moving;
      if (rev_done) begin
        steps_d = 8'd0;
        revs_d  = revs_adv;
      end else begin
        steps_d = steps_adv;
      end
    end
  end

  assign view_o.coils  = coils_d;
  assign view_o.driven = driven;
  assign view_o.mode   = mode_d;
  assign view_o.revs   = revs_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_COAST;
      target_q  <= 8'd0;
      fwd_idx_q <= FWD_IDX_INIT;
      rev_idx_q <= REV_IDX_INIT;
      steps_q   <= 8'd0;
      revs_q    <= 8'd0;
      coils_q   <= 4'd0;
    end else if (ctrl_i.en) begin
      mode_q    <= mode_d;
      target_q  <= target_d;
      fwd_idx_q <= fwd_idx_d;
      rev_idx_q <= rev_idx_d;
      steps_q   <= steps_d;
      revs_q    <= revs_d;
      coils_q   <= coils_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dual_stepper_revolution_sequencer.sv
// Top level: input register, command decode, two motor channels and result register.
//
//   channel | direction | handshake                  | payload
//   in      | sink      | in_valid_i / in_ready_o    | in_data_i  (dss_in_t)
//   out     | source    | out_valid_o / out_ready_i  | out_data_o (dss_out_t)
//
// One transaction per cycle sustained while the output is not stalled; the result passes
// through the input register, then the motor state update and the result register.
// The motor counters update in the same cycle the result register loads.
// Reset clears all motor state to coast with the phase indices at their start values.
// A stalled output holds one result; the input register can still take one more.
`timescale 1ns / 1ps
`default_nettype none

module dual_stepper_revolution_sequencer
  import dss_pkg::*;
#(
  parameter int unsigned StepsPerRev = STEPS_PER_REV_DEF
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  input  dss_in_t  in_data_i,
  output logic     out_valid_o,
  input  wire      out_ready_i,
  output dss_out_t out_data_o
);

  // Input register
  dss_in_t in_q;
  logic    in_valid_q;
  logic    fire;

  assign fire       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Command decode
  logic       is_tick, is_load, is_stop;
  logic [7:0] load_target;
  mode_e      first_load_mode, second_load_mode;
  logic [7:0] first_load_tgt, second_load_tgt;

  assign is_tick     = (in_q.command == CMD_TICK);
  assign is_load     = (in_q.command == CMD_LOAD);
  assign is_stop     = (in_q.command == CMD_STOP);
  assign load_target = (8'(in_q.target_tens) << 3) + (8'(in_q.target_tens) << 1)
                       + 8'(in_q.target_units);

  always_comb begin
    first_load_mode  = MODE_COAST;
    second_load_mode = MODE_COAST;
    first_load_tgt   = 8'd0;
    second_load_tgt  = 8'd0;
    unique case (in_q.mode_code)
      LOAD_FIRST_FWD: begin
        first_load_mode = MODE_FWD;
        first_load_tgt  = load_target;
      end
      LOAD_FIRST_REV: begin
        first_load_mode = MODE_REV;
        first_load_tgt  = load_target;
      end
      LOAD_SECOND_FWD: begin
        second_load_mode = MODE_FWD;
        second_load_tgt  = load_target;
      end
      LOAD_SECOND_REV: begin
        second_load_mode = MODE_REV;
        second_load_tgt  = load_target;
      end
      LOAD_BRAKE_BOTH: begin
        first_load_mode  = MODE_BRAKE;
        second_load_mode = MODE_BRAKE;
      end
      default: ;
    endcase
  end

  // Motor channels
  motor_ctrl_t first_ctrl, second_ctrl;
  motor_view_t first_view, second_view;
  motor_stat_t first_stat, second_stat;
  logic        halt;

  // Either motor reaching its target stops both
  assign halt = is_stop || first_stat.target_hit || second_stat.target_hit;

  always_comb begin
    first_ctrl.en           = fire;
    first_ctrl.tick         = is_tick;
    first_ctrl.load         = is_load;
    first_ctrl.load_mode    = first_load_mode;
    first_ctrl.load_target  = first_load_tgt;
    first_ctrl.halt         = halt;
    second_ctrl.en          = fire;
    second_ctrl.tick        = is_tick;
    second_ctrl.load        = is_load;
    second_ctrl.load_mode   = second_load_mode;
    second_ctrl.load_target = second_load_tgt;
    second_ctrl.halt        = halt;
  end

  dss_motor #(
    .StepsPerRev(StepsPerRev)
  ) u_first (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (first_ctrl),
    .view_o (first_view),
    .stat_o (first_stat)
  );

  dss_motor #(
    .StepsPerRev(StepsPerRev)
  ) u_second (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (second_ctrl),
    .view_o (second_view),
    .stat_o (second_stat)
  );

  // Red indicator: toggles per revolution, cleared on stop
  logic red_q, red_d;

  assign red_d = halt ? 1'b0 : (red_q ^ first_stat.rev_done ^ second_stat.rev_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q <= 1'b0;
    end else if (fire) begin
      red_q <= red_d;
    end
  end

  // Result register
  dss_out_t out_d;

  always_comb begin
    out_d.first_coils   = first_view.coils;
    out_d.first_driven  = first_view.driven;
    out_d.second_coils  = second_view.coils;
    out_d.second_driven = second_view.driven;
    out_d.first_mode    = first_view.mode;
    out_d.second_mode   = second_view.mode;
    out_d.red_indicator = red_d;
    out_d.stopped_now   = halt;
    out_d.first_revs    = first_view.revs;
    out_d.second_revs   = second_view.revs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_o <= out_d;
    end
  end

endmodule

`default_nettype wire
